// ===== src/tts_pkg.sv =====
// Package: widths, digit split and tube position helpers for the tube frame serializer.
package tts_pkg;

    localparam int unsigned FIELD_W     = 7;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned FRAME_W     = 64;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FRAME_BYTES = FRAME_W / BYTE_W;
    localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);
    localparam int unsigned POS_W       = 7;
    localparam int unsigned BIT_IDX_W   = $clog2(FRAME_W);
    localparam int unsigned S_TDATA_W   = ((3 * FIELD_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] BASE_SEC_ONES  = 7'd64;
    localparam logic [POS_W-1:0] BASE_SEC_TENS  = 7'd54;
    localparam logic [POS_W-1:0] BASE_MIN_ONES  = 7'd42;
    localparam logic [POS_W-1:0] BASE_MIN_TENS  = 7'd32;
    localparam logic [POS_W-1:0] BASE_HOUR_ONES = 7'd22;
    localparam logic [POS_W-1:0] BASE_HOUR_TENS = 7'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [FRAME_W-1:0] t_frame;

    typedef struct packed {
        t_field hours;
        t_field minutes;
        t_field seconds;
    } t_time;

    // Tens digit via reciprocal multiply: floor(v * 205 / 2048) is exact for v < 1024.
    function automatic t_digit tens_of(input t_field v);
        logic [FIELD_W+7:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic t_digit ones_of(input t_field v);
        logic [FIELD_W-1:0] r;
        r = v - FIELD_W'({3'd0, tens_of(v)} * 7'd10);
        return r[DIGIT_W-1:0];
    endfunction

endpackage

// ===== src/time_to_tube_frame_serializer.sv =====
// Top level: registers time values, builds the tube frame and streams it out byte by byte.
// When idle, an input is registered, then its first frame byte is registered at the output.
// Eight output transactions per input, one per cycle while i_m_axis_tready is high; a new input
// is taken while the previous frame drains, so frames follow back to back.
// The rate is set by the single byte-wide output port.
// Reset (synchronous, active low) empties the input and output registers and the byte counter.
module time_to_tube_frame_serializer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [6:0] hours, [13:7] minutes, [20:14] seconds, [23:21] zero
    input  logic [tts_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] frame_byte
    output logic [tts_pkg::BYTE_W-1:0]    o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);

    logic                       r_in_valid, n_in_valid;
    tts_pkg::t_time             r_time;
    tts_pkg::t_frame            r_frame, n_frame;
    logic [tts_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_o_valid, n_o_valid;
    logic [tts_pkg::BYTE_W-1:0] r_o_byte, n_o_byte;
    logic                       r_o_last, n_o_last;
    tts_pkg::t_frame            built;
    logic                       advance;
    logic                       consume;
    logic                       in_take;

    tts_frame_build u_build (
        .i_time  (r_time),
        .o_frame (built)
    );

    assign advance = !r_o_valid || i_m_axis_tready;
    assign consume = advance && (r_cnt == '0) && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || consume;
    assign in_take = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_frame   = r_frame;
        n_cnt     = r_cnt;
        n_o_valid = r_o_valid;
        n_o_byte  = r_o_byte;
        n_o_last  = r_o_last;
        if (advance) begin
            if (r_cnt != '0) begin
                n_o_valid = 1'b1;
                n_o_byte  = r_frame[tts_pkg::FRAME_W-1 -: tts_pkg::BYTE_W];
                n_o_last  = (r_cnt == tts_pkg::CNT_W'(1));
                n_frame   = r_frame << tts_pkg::BYTE_W;
                n_cnt     = r_cnt - tts_pkg::CNT_W'(1);
            end else if (r_in_valid) begin
                n_o_valid = 1'b1;
                n_o_byte  = built[tts_pkg::FRAME_W-1 -: tts_pkg::BYTE_W];
                n_o_last  = 1'b0;
                n_frame   = built << tts_pkg::BYTE_W;
                n_cnt     = tts_pkg::CNT_W'(tts_pkg::FRAME_BYTES - 1);
            end else begin
                n_o_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_time.hours   <= i_s_axis_tdata[tts_pkg::FIELD_W-1:0];
            r_time.minutes <= i_s_axis_tdata[2*tts_pkg::FIELD_W-1:tts_pkg::FIELD_W];
            r_time.seconds <= i_s_axis_tdata[3*tts_pkg::FIELD_W-1:2*tts_pkg::FIELD_W];
        end
        r_frame  <= n_frame;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_byte;
    assign o_m_axis_tlast  = r_o_last;

endmodule

// ===== src/tts_frame_build.sv =====
// Frame builder: turns one time value into the 64-bit active-low tube frame.
module tts_frame_build (
    input  tts_pkg::t_time  i_time,
    output tts_pkg::t_frame o_frame
);

    function automatic tts_pkg::t_frame light(
        input tts_pkg::t_frame          img,
        input logic [tts_pkg::POS_W-1:0] base,
        input tts_pkg::t_digit          d
    );
        logic [tts_pkg::POS_W-1:0] pos;
        tts_pkg::t_frame           res;
        res = img;
        if (d <= tts_pkg::DIGIT_MAX) begin
            if (d == '0) begin
                pos = base;
            end else begin
                pos = base - {3'd0, tts_pkg::DIGIT_TEN} + {3'd0, d};
            end
            pos = pos - 7'd1;
            res[pos[tts_pkg::BIT_IDX_W-1:0]] = 1'b0;
        end
        return res;
    endfunction

    always_comb begin
        tts_pkg::t_frame img;
        img = '1;
        img = light(img, tts_pkg::BASE_SEC_ONES,  tts_pkg::ones_of(i_time.seconds));
        img = light(img, tts_pkg::BASE_SEC_TENS,  tts_pkg::tens_of(i_time.seconds));
        img = light(img, tts_pkg::BASE_MIN_ONES,  tts_pkg::ones_of(i_time.minutes));
        img = light(img, tts_pkg::BASE_MIN_TENS,  tts_pkg::tens_of(i_time.minutes));
        img = light(img, tts_pkg::BASE_HOUR_ONES, tts_pkg::ones_of(i_time.hours));
        img = light(img, tts_pkg::BASE_HOUR_TENS, tts_pkg::tens_of(i_time.hours));
        o_frame = img;
    end

endmodule

// ===== src/tts_checker.sv =====
// Port checker for the tube frame serializer and its bind to the top level.
module tts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [tts_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [tts_pkg::BYTE_W-1:0]    o_m_axis_tdata,
    input logic                          o_m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output transaction changed");

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("gap inside a frame");

    a_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid && i_s_axis_tvalid && o_s_axis_tready |-> ##2 o_m_axis_tvalid)
        else $error("frame did not start after input transaction");

    a_known_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid |-> !$isunknown({o_m_axis_tdata, o_m_axis_tlast})) and
        (i_s_axis_tvalid |-> !$isunknown(i_s_axis_tdata)))
        else $error("unknown data on a valid transaction");

endmodule

bind time_to_tube_frame_serializer tts_checker u_tts_checker (.*);
